// ===== src/fcg_pkg.sv =====
// shared widths, register codes, reset values and state type of the frame change gate
package fcg_pkg;

   localparam int unsigned MAX_PIXELS_DEF = 4096;

   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned CTX_W      = 32;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned COUNT_W    = 13;
   localparam int unsigned THR_W      = 8;
   localparam int unsigned MEAN_W     = 15;
   localparam int unsigned PERMILLE_W = 10;
   localparam int unsigned TIMEOUT_W  = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // scale factors of the mean and changed-fraction tests
   localparam int unsigned MEAN_SCALE    = 100;
   localparam int unsigned MEAN_SCALE_W  = 7;
   localparam int unsigned CHANGED_SCALE = 1000;
   localparam int unsigned CHANGED_SCALE_W = 10;

   localparam logic [THR_W-1:0]      THR_RESET      = 8'd12;
   localparam logic [MEAN_W-1:0]     MEAN_RESET     = 15'd45;
   localparam logic [PERMILLE_W-1:0] PERMILLE_RESET = 10'd5;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 32'd30000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_THR     = 2'd0,
      CSR_MEAN_LIMIT    = 2'd1,
      CSR_CHANGED_LIMIT = 2'd2,
      CSR_TIMEOUT       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_ACC,
      ST_MUL,
      ST_DECIDE
   } state_type;

endpackage

// ===== src/fcg_req_if.sv =====
// pixel word channel of the frame change gate
interface fcg_req_if;
   import fcg_pkg::*;

   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  pixel;
   logic                last_pixel;
   logic [CTX_W-1:0]    context_id;
   logic [TIME_W-1:0]   time_ms;

   modport source (output valid, pixel, last_pixel, context_id, time_ms, input ready);
   modport sink   (input valid, pixel, last_pixel, context_id, time_ms, output ready);
endinterface

// ===== src/fcg_rsp_if.sv =====
// decision word channel of the frame change gate
interface fcg_rsp_if;
   import fcg_pkg::*;

   logic                valid;
   logic                ready;
   logic                take;
   logic [COUNT_W-1:0]  pixel_count;
   logic                too_long;

   modport source (output valid, take, pixel_count, too_long, input ready);
   modport sink   (input valid, take, pixel_count, too_long, output ready);
endinterface

// ===== src/frame_change_gate.sv =====
// frame change gate: per-frame change detector over a double-buffered reference frame
//
// frames arrive one pixel word per cycle on req_bus, the final word marked by last_pixel,
// whose context_id and time_ms are the ones that count. each pixel is written into the
// spare half of an on-chip frame buffer of 2*MAX_PIXELS bytes while the pixel at the same
// place in the reference half is read back through a registered read port and compared: absolute
// differences are summed and those above the threshold are counted. after the last word
// one decision word leaves on rsp_bus: take, the pixel count and a too-long flag. a frame
// is taken when its length or context differs from the reference, when time ran
// backwards, when the timeout has elapsed, or when the mean or changed fraction is above
// its limit; a taken frame becomes the reference by swapping buffer halves. pixels past
// MAX_PIXELS are dropped and the frame is reported too long and never taken.
// rate: one pixel per cycle inside a frame; after each last pixel the input pauses while the
// block accumulates the last pixel, forms the products, then compares and swaps, and longer
// only while the previous decision word still sits unread in the output register.
// buffer contents are undefined after reset; no clearing pass is needed since a reference
// is only compared against once a frame of the same length has filled it.
module frame_change_gate #(
   parameter int unsigned MAX_PIXELS = fcg_pkg::MAX_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   fcg_req_if.sink                         req_bus,
   fcg_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [fcg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fcg_pkg::*;

   // count holds 0..MAX_PIXELS, index addresses one half of the buffer
   localparam int unsigned CNT_W   = $clog2(MAX_PIXELS + 1);
   localparam int unsigned IDX_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int unsigned ADDR_W  = IDX_W + 1;
   localparam int unsigned DEPTH   = 2 ** ADDR_W;
   localparam int unsigned DIFF_W  = $clog2(255 * MAX_PIXELS + 1);
   // widths of the cross-multiplied comparisons
   localparam int unsigned MEAN_L_W = DIFF_W + MEAN_SCALE_W;
   localparam int unsigned MEAN_R_W = MEAN_W + CNT_W;
   localparam int unsigned MEAN_C_W = (MEAN_L_W > MEAN_R_W) ? MEAN_L_W : MEAN_R_W;
   localparam int unsigned CHG_L_W  = CNT_W + CHANGED_SCALE_W;
   localparam int unsigned CHG_R_W  = PERMILLE_W + CNT_W;
   localparam int unsigned CHG_C_W  = (CHG_L_W > CHG_R_W) ? CHG_L_W : CHG_R_W;

   // configuration registers
   logic [THR_W-1:0]      thr_ff;
   logic [MEAN_W-1:0]     mean_lim_ff;
   logic [PERMILLE_W-1:0] chg_lim_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   // control and reference state
   state_type             state_ff, state_in;
   logic                  active_ff, active_in;
   logic [CNT_W-1:0]      ref_count_ff, ref_count_in;
   logic [TIME_W-1:0]     saved_time_ff, saved_time_in;
   logic [CTX_W-1:0]      saved_ctx_ff, saved_ctx_in;

   // per-frame accumulators
   logic [DIFF_W-1:0]     diff_ff, diff_in;
   logic [CNT_W-1:0]      changed_ff, changed_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  ovf_ff, ovf_in;
   logic [CTX_W-1:0]      frame_ctx_ff;
   logic [TIME_W-1:0]     frame_time_ff;

   // compare stage
   logic                  s1_valid_ff;
   logic [PIXEL_W-1:0]    s1_pixel_ff;
   logic [PIXEL_W-1:0]    rd_data_ff;
   logic [MEAN_L_W-1:0]   mean_lhs_ff;
   logic [MEAN_R_W-1:0]   mean_rhs_ff;
   logic [CHG_L_W-1:0]    chg_lhs_ff;
   logic [CHG_R_W-1:0]    chg_rhs_ff;
   logic                  quick_take_ff;

   // decision word register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_take_ff, rsp_take_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_long_ff, rsp_long_in;

   // frame buffer, half selected by the top address bit
   logic [PIXEL_W-1:0]    frame_mem [DEPTH];

   logic                  in_ready;
   logic                  decide_go;
   logic                  req_fire;
   logic                  room;
   logic                  wr_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [PIXEL_W-1:0]    abs_diff;
   logic                  take;
   logic                  time_back;
   logic [TIME_W-1:0]     age;
   logic                  timed_out;

   // input side
   assign req_fire = req_bus.valid && req_bus.ready;
   assign room     = idx_ff < CNT_W'(MAX_PIXELS);
   assign wr_en    = req_fire && room;
   assign rd_addr  = {active_ff, idx_ff[IDX_W-1:0]};
   assign wr_addr  = {~active_ff, idx_ff[IDX_W-1:0]};

   assign req_bus.ready = in_ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.take        = rsp_take_ff;
   assign rsp_bus.pixel_count = rsp_count_ff;
   assign rsp_bus.too_long    = rsp_long_ff;

   // new pixel goes to the spare half, reference read from the active half
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= req_bus.pixel;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   // fsm: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_fire && req_bus.last_pixel) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (decide_go) begin
               state_in = ST_RUN;
            end
         end
         default:   state_in = ST_RUN;
      endcase
   end

   // fsm: outputs
   always_comb begin
      in_ready  = 1'b0;
      decide_go = 1'b0;
      case (state_ff)
         ST_RUN:    in_ready  = 1'b1;
         ST_DECIDE: decide_go = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            in_ready  = 1'b0;
            decide_go = 1'b0;
         end
      endcase
   end

   // absolute difference against the reference pixel
   assign abs_diff = (s1_pixel_ff >= rd_data_ff) ? (s1_pixel_ff - rd_data_ff)
                                                 : (rd_data_ff - s1_pixel_ff);

   // quick tests on length, context and time
   assign time_back = frame_time_ff < saved_time_ff;
   assign age       = frame_time_ff - saved_time_ff;
   assign timed_out = age >= TIME_W'(timeout_ff);

   // final decision from the registered products
   assign take = !ovf_ff && (quick_take_ff
                 || (MEAN_C_W'(mean_lhs_ff) > MEAN_C_W'(mean_rhs_ff))
                 || (CHG_C_W'(chg_lhs_ff) > CHG_C_W'(chg_rhs_ff)));

   // accumulators, reference update and decision word
   always_comb begin
      diff_in       = diff_ff;
      changed_in    = changed_ff;
      idx_in        = idx_ff;
      ovf_in        = ovf_ff;
      active_in     = active_ff;
      ref_count_in  = ref_count_ff;
      saved_time_in = saved_time_ff;
      saved_ctx_in  = saved_ctx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_take_in   = rsp_take_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_long_in   = rsp_long_ff;

      if (s1_valid_ff) begin
         diff_in = diff_ff + DIFF_W'(abs_diff);
         if (abs_diff > thr_ff) begin
            changed_in = changed_ff + CNT_W'(1);
         end
      end

      if (req_fire) begin
         if (room) begin
            idx_in = idx_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (decide_go) begin
         rsp_valid_in = 1'b1;
         rsp_take_in  = take;
         rsp_count_in = COUNT_W'(idx_ff);
         rsp_long_in  = ovf_ff;
         if (take) begin
            active_in     = ~active_ff;
            ref_count_in  = idx_ff;
            saved_time_in = frame_time_ff;
            saved_ctx_in  = frame_ctx_ff;
         end
         diff_in    = '0;
         changed_in = '0;
         idx_in     = '0;
         ovf_in     = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         active_ff     <= 1'b0;
         ref_count_ff  <= '0;
         saved_time_ff <= '0;
         saved_ctx_ff  <= '0;
         diff_ff       <= '0;
         changed_ff    <= '0;
         idx_ff        <= '0;
         ovf_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         ref_count_ff  <= ref_count_in;
         saved_time_ff <= saved_time_in;
         saved_ctx_ff  <= saved_ctx_in;
         diff_ff       <= diff_in;
         changed_ff    <= changed_in;
         idx_ff        <= idx_in;
         ovf_ff        <= ovf_in;
         s1_valid_ff   <= wr_en;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THR_RESET;
         mean_lim_ff <= MEAN_RESET;
         chg_lim_ff  <= PERMILLE_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_THR:     thr_ff      <= csr_wdata[THR_W-1:0];
            CSR_MEAN_LIMIT:    mean_lim_ff <= csr_wdata[MEAN_W-1:0];
            CSR_CHANGED_LIMIT: chg_lim_ff  <= csr_wdata[PERMILLE_W-1:0];
            CSR_TIMEOUT:       timeout_ff  <= csr_wdata[TIMEOUT_W-1:0];
            default:           thr_ff      <= thr_ff;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_pixel_ff <= req_bus.pixel;
      if (req_fire && req_bus.last_pixel) begin
         frame_ctx_ff  <= req_bus.context_id;
         frame_time_ff <= req_bus.time_ms;
      end
      // products settle while accumulators hold after the last pixel
      mean_lhs_ff   <= MEAN_L_W'(diff_ff) * MEAN_L_W'(MEAN_SCALE);
      mean_rhs_ff   <= MEAN_R_W'(mean_lim_ff) * MEAN_R_W'(idx_ff);
      chg_lhs_ff    <= CHG_L_W'(changed_ff) * CHG_L_W'(CHANGED_SCALE);
      chg_rhs_ff    <= CHG_R_W'(chg_lim_ff) * CHG_R_W'(idx_ff);
      quick_take_ff <= (idx_ff != ref_count_ff) || (frame_ctx_ff != saved_ctx_ff)
                       || time_back || timed_out;
      rsp_take_ff   <= rsp_take_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_long_ff   <= rsp_long_in;
   end

endmodule

// ===== verif/frame_change_gate_tb.sv =====
// self-checking testbench of the frame change gate: random and directed frames, scoreboard
`timescale 1ns / 1ps

module frame_change_gate_tb;
   import fcg_pkg::*;

   localparam int unsigned MAX_PIX = MAX_PIXELS_DEF;
   // receiver hold-off long enough to back the block up into its input
   localparam int unsigned HOLD_CYCLES = 400;

   // one pixel word as queued for the driver
   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
      logic [CTX_W-1:0]   ctx;
      logic [TIME_W-1:0]  tm;
   } pixel_word_type;

   // one decision word as it should leave the block
   typedef struct packed {
      logic               take;
      logic [COUNT_W-1:0] pixel_count;
      logic               too_long;
   } decision_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fcg_req_if req_bus ();
   fcg_rsp_if rsp_bus ();

   frame_change_gate dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // pixel words waiting for the driver, decision words waiting for the monitor
   pixel_word_type pixel_backlog[$];
   decision_type   awaited_decisions[$];

   int unsigned error_total = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;

   // long receiver stall, asked for by the stimulus and carried out by the monitor
   bit          pressure_req = 1'b0;
   bit          pressure_done;
   int unsigned hold_left;

   // ------------------------------------------------------------------
   // predictor: own copy of the frame buffer, reference and accumulators
   // ------------------------------------------------------------------
   logic [PIXEL_W-1:0]    ref_store [0:2*MAX_PIX-1];
   logic                  shadow_half;
   int unsigned           shadow_ref_count;
   logic [TIME_W-1:0]     shadow_time;
   logic [CTX_W-1:0]      shadow_ctx;
   int unsigned           sum_abs_diff;
   int unsigned           n_changed;
   int unsigned           n_pixels;
   bit                    frame_overflow;

   logic [THR_W-1:0]      cfg_thr;
   logic [MEAN_W-1:0]     cfg_mean;
   logic [PERMILLE_W-1:0] cfg_permille;
   logic [TIMEOUT_W-1:0]  cfg_timeout;

   // scores one accepted pixel word, queues a decision on the last pixel
   function automatic void score_pixel(input logic [PIXEL_W-1:0] px, input logic last,
                                       input logic [CTX_W-1:0] ctx,
                                       input logic [TIME_W-1:0] tm);
      int unsigned       ref_px;
      int unsigned       gap;
      int unsigned       base_ref;
      int unsigned       base_new;
      longint unsigned   n;
      logic              take;
      decision_type      verdict;
      if (n_pixels < MAX_PIX) begin
         base_ref = shadow_half ? MAX_PIX : 0;
         base_new = shadow_half ? 0 : MAX_PIX;
         ref_px   = ref_store[base_ref + n_pixels];
         gap      = (px >= ref_px) ? px - ref_px : ref_px - px;
         sum_abs_diff += gap;
         if (gap > cfg_thr)
            n_changed++;
         ref_store[base_new + n_pixels] = px;
         n_pixels++;
      end else begin
         // pixels past capacity are dropped
         frame_overflow = 1'b1;
      end
      if (last) begin
         n = n_pixels;
         if (frame_overflow) begin
            take = 1'b0;
         end else begin
            take = (n_pixels != shadow_ref_count) || (ctx != shadow_ctx) || (tm < shadow_time);
            if (!take && (tm - shadow_time) >= 48'(cfg_timeout))
               take = 1'b1;
            if (!take && 64'(sum_abs_diff) * 64'(MEAN_SCALE) > 64'(cfg_mean) * n)
               take = 1'b1;
            if (!take && 64'(n_changed) * 64'(CHANGED_SCALE) > 64'(cfg_permille) * n)
               take = 1'b1;
         end
         if (take) begin
            // taken frame becomes the reference
            shadow_half      = ~shadow_half;
            shadow_ref_count = n_pixels;
            shadow_ctx       = ctx;
            shadow_time      = tm;
         end
         verdict.take        = take;
         verdict.pixel_count = COUNT_W'(n_pixels);
         verdict.too_long    = frame_overflow;
         awaited_decisions = {awaited_decisions, verdict};
         sum_abs_diff   = 0;
         n_changed      = 0;
         n_pixels       = 0;
         frame_overflow = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // driver: offers queued pixel words, idles at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_word_type w;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.pixel      <= '0;
         req_bus.last_pixel <= 1'b0;
         req_bus.context_id <= '0;
         req_bus.time_ms    <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            score_pixel(req_bus.pixel, req_bus.last_pixel, req_bus.context_id, req_bus.time_ms);
         if (!req_bus.valid || req_bus.ready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               w = pixel_backlog.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.pixel      <= w.pixel;
               req_bus.last_pixel <= w.last;
               req_bus.context_id <= w.ctx;
               req_bus.time_ms    <= w.tm;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: checks each decision word against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         pressure_done <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_decisions.size() == 0) begin
               $error("decision word with none expected: take %0d, pixel_count %0d, too_long %0d",
                      rsp_bus.take, rsp_bus.pixel_count, rsp_bus.too_long);
               error_total++;
            end else begin
               want = awaited_decisions.pop_front();
               if (rsp_bus.take !== want.take) begin
                  $error("take: expected %0d, got %0d", want.take, rsp_bus.take);
                  error_total++;
               end
               if (rsp_bus.pixel_count !== want.pixel_count) begin
                  $error("pixel_count: expected %0d, got %0d", want.pixel_count,
                         rsp_bus.pixel_count);
                  error_total++;
               end
               if (rsp_bus.too_long !== want.too_long) begin
                  $error("too_long: expected %0d, got %0d", want.too_long, rsp_bus.too_long);
                  error_total++;
               end
            end
         end
         // the long stall is counted here, the sender carries on regardless
         if (pressure_req && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   // scene the frames are drawn from; steady frames are the scene plus noise
   logic [PIXEL_W-1:0] scene [0:MAX_PIX-1];
   int unsigned        scene_len;
   logic [CTX_W-1:0]   gen_ctx;
   logic [TIME_W-1:0]  gen_time;

   // queues one frame; only the last word's context and time count, others get junk
   task automatic push_frame(input int len, input int noise, input logic [CTX_W-1:0] ctx,
                             input logic [TIME_W-1:0] tm);
      pixel_word_type w;
      int             v;
      for (int k = 0; k < len; k++) begin
         v = (k < MAX_PIX) ? int'(scene[k]) : int'($urandom_range(255));
         if (noise > 0)
            v = v + int'($urandom_range(2 * noise)) - noise;
         if (v < 0)
            v = 0;
         if (v > 255)
            v = 255;
         w.pixel = PIXEL_W'(v);
         w.last  = (k == len - 1);
         w.ctx   = w.last ? ctx : CTX_W'($urandom);
         w.tm    = w.last ? tm : TIME_W'({$urandom, $urandom});
         pixel_backlog = {pixel_backlog, w};
      end
   endtask

   // register write with junk above the register's width, which must be ignored
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] data;
      junk = $urandom;
      case (idx)
         CSR_PIXEL_THR: begin
            data    = {junk[CSR_DATA_W-1:THR_W], value[THR_W-1:0]};
            cfg_thr = value[THR_W-1:0];
         end
         CSR_MEAN_LIMIT: begin
            data     = {junk[CSR_DATA_W-1:MEAN_W], value[MEAN_W-1:0]};
            cfg_mean = value[MEAN_W-1:0];
         end
         CSR_CHANGED_LIMIT: begin
            data         = {junk[CSR_DATA_W-1:PERMILLE_W], value[PERMILLE_W-1:0]};
            cfg_permille = value[PERMILLE_W-1:0];
         end
         default: begin
            data        = value;
            cfg_timeout = value[TIMEOUT_W-1:0];
         end
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_limits(input int unsigned thr, input int unsigned mean,
                               input int unsigned permille, input logic [31:0] timeout);
      csr_write(CSR_PIXEL_THR, thr);
      csr_write(CSR_MEAN_LIMIT, mean);
      csr_write(CSR_CHANGED_LIMIT, permille);
      csr_write(CSR_TIMEOUT, timeout);
   endtask

   // waits until every word is through and the decision pipeline has emptied
   task automatic settle();
      while (pixel_backlog.size() != 0 || req_bus.valid || awaited_decisions.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // random frames, mostly repeats of the scene so that the limits decide
   task automatic random_frames(input int budget);
      int          pushed;
      int unsigned roll;
      int          len;
      int          noise;
      pushed = 0;
      while (pushed < budget) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            // new scene, mostly short frames
            scene_len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            for (int k = 0; k < scene_len; k++)
               scene[k] = PIXEL_W'($urandom);
            if ($urandom_range(1))
               gen_ctx = $urandom;
         end else if (roll < 18) begin
            gen_ctx = $urandom;
         end
         roll = $urandom_range(99);
         if (roll < 6)
            gen_time = gen_time - TIME_W'($urandom_range(1, 1000));
         else if (roll < 14)
            gen_time = gen_time + TIME_W'(cfg_timeout) + TIME_W'($urandom_range(2)) - 1;
         else if (roll < 17)
            gen_time = TIME_W'({$urandom, $urandom});
         else
            gen_time = gen_time + TIME_W'($urandom_range(50));
         roll = $urandom_range(99);
         if (roll < 50)
            noise = $urandom_range(2);
         else if (roll < 85)
            noise = $urandom_range(3, 20);
         else
            noise = $urandom_range(21, 255);
         len = scene_len;
         if ($urandom_range(19) == 0)
            len = ($urandom_range(1) || len == 1) ? len + 1 : len - 1;
         push_frame(len, noise, gen_ctx, gen_time);
         pushed += len;
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;

      // predictor reset state
      for (int k = 0; k < 2 * MAX_PIX; k++)
         ref_store[k] = '0;
      shadow_half      = 1'b0;
      shadow_ref_count = 0;
      shadow_time      = '0;
      shadow_ctx       = '0;
      sum_abs_diff     = 0;
      n_changed        = 0;
      n_pixels         = 0;
      frame_overflow   = 1'b0;
      cfg_thr          = THR_RESET;
      cfg_mean         = MEAN_RESET;
      cfg_permille     = PERMILLE_RESET;
      cfg_timeout      = TIMEOUT_RESET;

      // scene starts as a ramp so that every entry holds a defined level
      for (int k = 0; k < MAX_PIX; k++)
         scene[k] = PIXEL_W'(k);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase 0: reset limits, sender idles lightly, receiver heavily
      sender_idle_pct   = 12;
      receiver_idle_pct = 72;

      // single-pixel frames walking through the timing cases
      scene[0] = 8'hFF;
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd100);    // no reference yet, length differs
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd100);    // identical, kept
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd30099);  // one short of the timeout
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd30100);  // timeout reached exactly
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd30099);  // time ran backwards
      scene[0] = 8'h00;
      push_frame(1, 0, 32'hA5A5_5A5A, 48'd30100);  // full swing, mean over limit
      push_frame(1, 0, 32'h5A5A_A5A5, 48'd30101);  // context change alone
      // mean right at its limit and one level over
      for (int k = 0; k < 20; k++)
         scene[k] = 8'd128;
      push_frame(20, 0, 32'h5A5A_A5A5, 48'd30102);
      for (int k = 0; k < 9; k++)
         scene[k] = 8'd129;
      push_frame(20, 0, 32'h5A5A_A5A5, 48'd30103);
      scene[9] = 8'd129;
      push_frame(20, 0, 32'h5A5A_A5A5, 48'd30104);
      scene_len = 20;
      gen_ctx   = 32'h5A5A_A5A5;
      gen_time  = 48'd30104;
      random_frames(120);
      settle();

      // phase 1: every limit at its floor, timeout at its ceiling
      write_limits(0, 0, 0, 32'hFFFF_FFFF);
      random_frames(120);
      settle();

      // phase 2: limits at their ceilings, zero timeout takes every frame
      sender_idle_pct   = 72;
      receiver_idle_pct = 12;
      write_limits(255, 25500, 1000, 32'd0);
      random_frames(120);
      settle();

      // phase 3: ceilings everywhere, only length, context and time decide
      write_limits(255, 25500, 1000, 32'hFFFF_FFFF);
      random_frames(120);
      settle();

      // phase 4: no idling, mid limits, receiver holds off long enough to back up
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_limits($urandom_range(40), $urandom_range(800), $urandom_range(300),
                   $urandom_range(200));
      pressure_req = 1'b1;
      random_frames(200);
      settle();

      // phase 5: no idling, other mid limits
      write_limits($urandom_range(40), $urandom_range(800), $urandom_range(300),
                   $urandom_range(200));
      random_frames(120);
      settle();

      repeat (20) @(posedge clock);
      if (error_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/fcg_pkg.sv
src/fcg_req_if.sv
src/fcg_rsp_if.sv
src/frame_change_gate.sv
verif/frame_change_gate_tb.sv
